// ===== src/ldpm_pkg.sv =====
// Shared types, constants and fixed-point helpers for the lens distortion point map.
`timescale 1ns / 1ps

package ldpm_pkg;

  localparam int PIXEL_BITS_DEF = 12;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int COORD_W        = 32;
  localparam int SUM_W          = 48;
  localparam int NUM_STAGES     = 9;
  localparam int OUT_DATA_W     = 2 * COORD_W;

  localparam logic signed [SUM_W-1:0] S32_MAX = 48'sd2147483647;
  localparam logic signed [SUM_W-1:0] S32_MIN = -48'sd2147483648;
  localparam logic signed [SUM_W-1:0] ONE_Q24 = 48'sd16777216;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_XY = 3'd0,
    REG_INV_FX    = 3'd1,
    REG_INV_FY    = 3'd2,
    REG_K1        = 3'd3,
    REG_K2        = 3'd4,
    REG_K3        = 3'd5,
    REG_P1        = 3'd6,
    REG_P2        = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [15:0]                center_y;
    logic [15:0]                center_x;
    logic [23:0]                inv_fx;
    logic [23:0]                inv_fy;
    logic signed [COORD_W-1:0]  k1;
    logic signed [COORD_W-1:0]  k2;
    logic signed [COORD_W-1:0]  k3;
    logic signed [COORD_W-1:0]  p1;
    logic signed [COORD_W-1:0]  p2;
  } cfg_t;

  typedef struct packed {
    logic                       clipped;
    logic signed [COORD_W-1:0]  mapped_y;
    logic signed [COORD_W-1:0]  mapped_x;
  } result_t;

  typedef struct packed {
    logic                       clip;
    logic signed [COORD_W-1:0]  val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [SUM_W-1:0] v);
    sat_t r;
    priority if (v > S32_MAX) begin
      r.clip = 1'b1;
      r.val  = COORD_W'(S32_MAX);
    end else if (v < S32_MIN) begin
      r.clip = 1'b1;
      r.val  = COORD_W'(S32_MIN);
    end else begin
      r.clip = 1'b0;
      r.val  = COORD_W'(v);
    end
    return r;
  endfunction

  // Q7.24 x Q7.24, round half up, saturate
  function automatic sat_t qmul(input logic signed [COORD_W-1:0] a,
                                input logic signed [COORD_W-1:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return sat32(SUM_W'((p + 64'sd8388608) >>> 24));
  endfunction

  // ((pix << 4) - c) * inv, Q.28 rounded to Q.24
  function automatic sat_t normalize(input logic [15:0] pix, input logic [15:0] c,
                                     input logic [23:0] inv);
    logic signed [21:0] d;
    logic signed [SUM_W-1:0] p;
    d = $signed({2'b00, pix, 4'b0000}) - $signed({6'b000000, c});
    p = SUM_W'(d) * SUM_W'($signed({1'b0, inv}));
    return sat32((p + 48'sd8) >>> 4);
  endfunction

endpackage

// ===== src/ldpm_cfg.sv =====
// Configuration register file for the lens distortion coefficients.
`timescale 1ns / 1ps

module ldpm_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_wr_en_i,
  input  logic [ldpm_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  logic [ldpm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output ldpm_pkg::cfg_t                    cfg_o
);

  ldpm_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr_en_i) begin
      unique case (ldpm_pkg::reg_idx_e'(cfg_addr_i))
        ldpm_pkg::REG_CENTER_XY: begin
          cfg_d.center_x = cfg_wdata_i[15:0];
          cfg_d.center_y = cfg_wdata_i[31:16];
        end
        ldpm_pkg::REG_INV_FX: cfg_d.inv_fx = cfg_wdata_i[23:0];
        ldpm_pkg::REG_INV_FY: cfg_d.inv_fy = cfg_wdata_i[23:0];
        ldpm_pkg::REG_K1:     cfg_d.k1     = $signed(cfg_wdata_i);
        ldpm_pkg::REG_K2:     cfg_d.k2     = $signed(cfg_wdata_i);
        ldpm_pkg::REG_K3:     cfg_d.k3     = $signed(cfg_wdata_i);
        ldpm_pkg::REG_P1:     cfg_d.p1     = $signed(cfg_wdata_i);
        ldpm_pkg::REG_P2:     cfg_d.p2     = $signed(cfg_wdata_i);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/ldpm_datapath.sv =====
// Nine-stage Brown-Conrady pipeline, at most one multiply level per stage.
`timescale 1ns / 1ps

module ldpm_datapath #(
  parameter int PIXEL_BITS = ldpm_pkg::PIXEL_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   in_valid_i,
  input  logic [PIXEL_BITS-1:0]  px_i,
  input  logic [PIXEL_BITS-1:0]  py_i,
  input  ldpm_pkg::cfg_t         cfg_i,
  output logic                   out_valid_o,
  output ldpm_pkg::result_t      out_o
);

  localparam int W = ldpm_pkg::COORD_W;
  localparam int S = ldpm_pkg::SUM_W;

  logic [ldpm_pkg::NUM_STAGES-1:0] vld_q;

  // stage registers
  logic signed [W-1:0] x1_q, y1_q;
  logic                c1_q;
  logic signed [W-1:0] x2_q, y2_q, xx2_q, yy2_q, xy2_q;
  logic                c2_q;
  logic signed [W-1:0] x3_q, y3_q, xx3_q, yy3_q, xy3_q, r2_3_q;
  logic                c3_q;
  logic signed [W-1:0] x4_q, y4_q, r2_4_q, r4_4_q, bx4_q, by4_q, k1r2_4_q, p1xy4_q, p2xy4_q;
  logic                c4_q;
  logic signed [W-1:0] x5_q, y5_q, r6_5_q, k2r4_5_q, p2bx5_q, p1by5_q, k1r2_5_q;
  logic signed [W-1:0] p1xy5_q, p2xy5_q;
  logic                c5_q;
  logic signed [W-1:0] x6_q, y6_q, k1r2_6_q, k2r4_6_q, k3r6_6_q, p2bx6_q, p1by6_q;
  logic signed [W-1:0] p1xy6_q, p2xy6_q;
  logic                c6_q;
  logic signed [W-1:0] x7_q, y7_q, rad7_q, p2bx7_q, p1by7_q, p1xy7_q, p2xy7_q;
  logic                c7_q;
  logic signed [W-1:0] xr8_q, yr8_q, p2bx8_q, p1by8_q, p1xy8_q, p2xy8_q;
  logic                c8_q;
  ldpm_pkg::result_t   res9_q;

  // combinational results per stage
  ldpm_pkg::sat_t nx, ny;
  ldpm_pkg::sat_t mxx, myy, mxy;
  ldpm_pkg::sat_t sr2;
  ldpm_pkg::sat_t mr4, sbx, sby, mk1r2, mp1xy, mp2xy;
  ldpm_pkg::sat_t mr6, mk2r4, mp2bx, mp1by;
  ldpm_pkg::sat_t mk3r6;
  ldpm_pkg::sat_t srad;
  ldpm_pkg::sat_t mxr, myr;
  ldpm_pkg::sat_t smx, smy;

  always_comb begin
    nx    = ldpm_pkg::normalize(16'(px_i), cfg_i.center_x, cfg_i.inv_fx);
    ny    = ldpm_pkg::normalize(16'(py_i), cfg_i.center_y, cfg_i.inv_fy);

    mxx   = ldpm_pkg::qmul(x1_q, x1_q);
    myy   = ldpm_pkg::qmul(y1_q, y1_q);
    mxy   = ldpm_pkg::qmul(x1_q, y1_q);

    sr2   = ldpm_pkg::sat32(S'(xx2_q) + S'(yy2_q));

    mr4   = ldpm_pkg::qmul(r2_3_q, r2_3_q);
    sbx   = ldpm_pkg::sat32(S'(r2_3_q) + (S'(xx3_q) <<< 1));
    sby   = ldpm_pkg::sat32(S'(r2_3_q) + (S'(yy3_q) <<< 1));
    mk1r2 = ldpm_pkg::qmul(cfg_i.k1, r2_3_q);
    mp1xy = ldpm_pkg::qmul(cfg_i.p1, xy3_q);
    mp2xy = ldpm_pkg::qmul(cfg_i.p2, xy3_q);

    mr6   = ldpm_pkg::qmul(r4_4_q, r2_4_q);
    mk2r4 = ldpm_pkg::qmul(cfg_i.k2, r4_4_q);
    mp2bx = ldpm_pkg::qmul(cfg_i.p2, bx4_q);
    mp1by = ldpm_pkg::qmul(cfg_i.p1, by4_q);

    mk3r6 = ldpm_pkg::qmul(cfg_i.k3, r6_5_q);

    srad  = ldpm_pkg::sat32(ldpm_pkg::ONE_Q24 + S'(k1r2_6_q) + S'(k2r4_6_q) + S'(k3r6_6_q));

    mxr   = ldpm_pkg::qmul(x7_q, rad7_q);
    myr   = ldpm_pkg::qmul(y7_q, rad7_q);

    // doubled terms use twice the rounded product
    smx   = ldpm_pkg::sat32(S'(xr8_q) + (S'(p1xy8_q) <<< 1) + S'(p2bx8_q));
    smy   = ldpm_pkg::sat32(S'(yr8_q) + S'(p1by8_q) + (S'(p2xy8_q) <<< 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[ldpm_pkg::NUM_STAGES-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x1_q     <= nx.val;
      y1_q     <= ny.val;
      c1_q     <= nx.clip | ny.clip;

      x2_q     <= x1_q;
      y2_q     <= y1_q;
      xx2_q    <= mxx.val;
      yy2_q    <= myy.val;
      xy2_q    <= mxy.val;
      c2_q     <= c1_q | mxx.clip | myy.clip | mxy.clip;

      x3_q     <= x2_q;
      y3_q     <= y2_q;
      xx3_q    <= xx2_q;
      yy3_q    <= yy2_q;
      xy3_q    <= xy2_q;
      r2_3_q   <= sr2.val;
      c3_q     <= c2_q | sr2.clip;

      x4_q     <= x3_q;
      y4_q     <= y3_q;
      r2_4_q   <= r2_3_q;
      r4_4_q   <= mr4.val;
      bx4_q    <= sbx.val;
      by4_q    <= sby.val;
      k1r2_4_q <= mk1r2.val;
      p1xy4_q  <= mp1xy.val;
      p2xy4_q  <= mp2xy.val;
      c4_q     <= c3_q | mr4.clip | sbx.clip | sby.clip | mk1r2.clip | mp1xy.clip
                  | mp2xy.clip;

      x5_q     <= x4_q;
      y5_q     <= y4_q;
      r6_5_q   <= mr6.val;
      k2r4_5_q <= mk2r4.val;
      p2bx5_q  <= mp2bx.val;
      p1by5_q  <= mp1by.val;
      k1r2_5_q <= k1r2_4_q;
      p1xy5_q  <= p1xy4_q;
      p2xy5_q  <= p2xy4_q;
      c5_q     <= c4_q | mr6.clip | mk2r4.clip | mp2bx.clip | mp1by.clip;

      x6_q     <= x5_q;
      y6_q     <= y5_q;
      k1r2_6_q <= k1r2_5_q;
      k2r4_6_q <= k2r4_5_q;
      k3r6_6_q <= mk3r6.val;
      p2bx6_q  <= p2bx5_q;
      p1by6_q  <= p1by5_q;
      p1xy6_q  <= p1xy5_q;
      p2xy6_q  <= p2xy5_q;
      c6_q     <= c5_q | mk3r6.clip;

      x7_q     <= x6_q;
      y7_q     <= y6_q;
      rad7_q   <= srad.val;
      p2bx7_q  <= p2bx6_q;
      p1by7_q  <= p1by6_q;
      p1xy7_q  <= p1xy6_q;
      p2xy7_q  <= p2xy6_q;
      c7_q     <= c6_q | srad.clip;

      xr8_q    <= mxr.val;
      yr8_q    <= myr.val;
      p2bx8_q  <= p2bx7_q;
      p1by8_q  <= p1by7_q;
      p1xy8_q  <= p1xy7_q;
      p2xy8_q  <= p2xy7_q;
      c8_q     <= c7_q | mxr.clip | myr.clip;

      res9_q.mapped_x <= smx.val;
      res9_q.mapped_y <= smy.val;
      res9_q.clipped  <= c8_q | smx.clip | smy.clip;
    end
  end

  assign out_valid_o = vld_q[ldpm_pkg::NUM_STAGES-1];
  assign out_o       = res9_q;

endmodule

// ===== src/ldpm_skid.sv =====
// Output register with a skid slot so the pipeline stalls only on a registered ready.
`timescale 1ns / 1ps

module ldpm_skid (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  ldpm_pkg::result_t  in_data_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output ldpm_pkg::result_t  out_data_o,
  input  logic               out_ready_i
);

  logic              out_valid_q, skid_valid_q;
  ldpm_pkg::result_t out_q, skid_q;

  assign in_ready_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready_i || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= in_valid_i;
      end
    end else if (in_valid_i && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : in_data_i;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/lens_distortion_point_map_top.sv =====
// Lens distortion point map: top level with streams, register port and pipeline.
// Usage:
//   Slave stream carries pixel coordinates (tdata: pixel_x, then pixel_y, each
//   PIXEL_BITS wide, zero padded to whole bytes). One transfer per ready clock.
//   Master stream returns mapped_x and mapped_y (signed Q7.24) in tdata and the
//   saturation flag clipped in tuser, one result per input transfer, in order.
//   Registers are written through cfg_wr_en_i / cfg_addr_i / cfg_wdata_i while
//   no item is in flight; indexes 0..7 follow the coefficient list.
// Timing:
//   An input transfer loads the first of nine pipeline stages, each with at most
//   one multiply level; the result then passes the output register, where tvalid
//   rises and, with tready high, the result transfers.
//   Throughput is one item per cycle while s_axis_tready is high: every stage
//   takes a new item each clock unless the pipeline holds.
// Reset: rst_ni clears the config and valid registers and empties the pipeline.
// Stall: when the receiver holds tready low, one more result lands in a skid
//   slot; s_axis_tready then drops and the whole pipeline holds until the
//   skid slot drains. Nothing is dropped or repeated.
`timescale 1ns / 1ps

module lens_distortion_point_map_top #(
  parameter int PIXEL_BITS = ldpm_pkg::PIXEL_BITS_DEF,
  localparam int IN_DATA_W = ((2 * PIXEL_BITS + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pixel_x, pixel_y, zero padding
  input  logic [IN_DATA_W-1:0]              s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // mapped_x, mapped_y
  output logic [ldpm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // clipped
  output logic                              m_axis_tuser,
  input  logic                              cfg_wr_en_i,
  input  logic [ldpm_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  logic [ldpm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  ldpm_pkg::cfg_t    cfg;
  ldpm_pkg::result_t pipe_res, out_res;
  logic              pipe_valid, adv;

  ldpm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_en_i (cfg_wr_en_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ldpm_datapath #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (s_axis_tvalid),
    .px_i        (s_axis_tdata[PIXEL_BITS-1:0]),
    .py_i        (s_axis_tdata[2*PIXEL_BITS-1:PIXEL_BITS]),
    .cfg_i       (cfg),
    .out_valid_o (pipe_valid),
    .out_o       (pipe_res)
  );

  ldpm_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pipe_valid),
    .in_data_i   (pipe_res),
    .in_ready_o  (adv),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_res),
    .out_ready_i (m_axis_tready)
  );

  assign s_axis_tready = adv;
  assign m_axis_tdata  = {out_res.mapped_y, out_res.mapped_x};
  assign m_axis_tuser  = out_res.clipped;

endmodule

// ===== src/ldpm_checker.sv =====
// Port-level assertions for the lens distortion point map, bound to the top level.
`timescale 1ns / 1ps

module ldpm_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tready,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [ldpm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            m_axis_tuser
);

  // held result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output transfer dropped while stalled");

  // held result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output payload changed while stalled");

  // input backpressure only comes from a stalled output
  a_bp_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // skid slot stays full while output is still stalled
  a_bp_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready && !m_axis_tready |=> !s_axis_tready)
    else $error("skid slot released while output stalled");

endmodule

bind lens_distortion_point_map_top ldpm_checker u_ldpm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb_top.sv =====
// Self-checking bench for the lens distortion point map: streams pixels, predicts, compares.
`timescale 1ns / 1ps

module tb_top;

  localparam int     LATENCY    = 10;
  localparam int     CYCLE_CAP  = 200000;
  localparam int     RAND_PHASES = 10;
  localparam int     PHASE_ITEMS = 130;
  localparam longint SAT_HI     = 64'sd2147483647;
  localparam longint SAT_LO     = -64'sd2147483648;
  localparam longint Q24_ONE    = 64'sd16777216;
  localparam longint Q24_HALF   = 64'sd8388608;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_HOLD, RX_TOGGLE} rx_mode_e;
  typedef enum int {SETUP_LENS, SETUP_RAW, SETUP_EDGE} setup_style_e;

  // Brown-Conrady predictor plus the queue of mappings still owed by the block
  class distortion_scoreboard;
    logic [15:0]        cen_x = '0;
    logic [15:0]        cen_y = '0;
    logic [23:0]        inv_fx = '0;
    logic [23:0]        inv_fy = '0;
    longint             k1, k2, k3, p1, p2;
    bit                 clip_seen;
    ldpm_pkg::result_t  pending_mappings[$];
    int                 bad_mappings;

    function void set_reg(ldpm_pkg::reg_idx_e idx, logic [31:0] value);
      case (idx)
        ldpm_pkg::REG_CENTER_XY: begin
          cen_x = value[15:0];
          cen_y = value[31:16];
        end
        ldpm_pkg::REG_INV_FX: inv_fx = value[23:0];
        ldpm_pkg::REG_INV_FY: inv_fy = value[23:0];
        ldpm_pkg::REG_K1:     k1 = longint'($signed(value));
        ldpm_pkg::REG_K2:     k2 = longint'($signed(value));
        ldpm_pkg::REG_K3:     k3 = longint'($signed(value));
        ldpm_pkg::REG_P1:     p1 = longint'($signed(value));
        ldpm_pkg::REG_P2:     p2 = longint'($signed(value));
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > SAT_HI) begin
        clip_seen = 1'b1;
        return SAT_HI;
      end
      if (v < SAT_LO) begin
        clip_seen = 1'b1;
        return SAT_LO;
      end
      return v;
    endfunction

    // >>> on a signed 64-bit value is a floor, so halves round toward +inf
    function longint q24_mul(longint a, longint b);
      return clamp32((a * b + Q24_HALF) >>> 24);
    endfunction

    function longint to_norm(logic [11:0] pix, logic [15:0] c, logic [23:0] inv);
      longint d;
      d = longint'(pix) * 16 - longint'(c);
      return clamp32((d * longint'(inv) + 8) >>> 4);
    endfunction

    function ldpm_pkg::result_t predict_mapping(logic [11:0] px, logic [11:0] py);
      longint  x, y, x2, y2, xy, r2, r4, r6, radial, bx, by, mx, my;
      ldpm_pkg::result_t r;
      clip_seen = 1'b0;
      x      = to_norm(px, cen_x, inv_fx);
      y      = to_norm(py, cen_y, inv_fy);
      x2     = q24_mul(x, x);
      y2     = q24_mul(y, y);
      xy     = q24_mul(x, y);
      r2     = clamp32(x2 + y2);
      r4     = q24_mul(r2, r2);
      r6     = q24_mul(r4, r2);
      radial = clamp32(Q24_ONE + q24_mul(k1, r2) + q24_mul(k2, r4) + q24_mul(k3, r6));
      bx     = clamp32(r2 + 2 * x2);
      by     = clamp32(r2 + 2 * y2);
      mx     = clamp32(q24_mul(x, radial) + 2 * q24_mul(p1, xy) + q24_mul(p2, bx));
      my     = clamp32(q24_mul(y, radial) + q24_mul(p1, by) + 2 * q24_mul(p2, xy));
      r.mapped_x = mx[31:0];
      r.mapped_y = my[31:0];
      r.clipped  = clip_seen;
      return r;
    endfunction

    function void note_pixel(logic [11:0] px, logic [11:0] py);
      pending_mappings.push_back(predict_mapping(px, py));
    endfunction

    function void check_mapping(logic [63:0] data, logic flag);
      ldpm_pkg::result_t want;
      if (pending_mappings.size() == 0) begin
        bad_mappings++;
        if (bad_mappings <= 10)
          $display("unexpected result: x %0d y %0d clipped %0b",
                   $signed(data[31:0]), $signed(data[63:32]), flag);
        return;
      end
      want = pending_mappings.pop_front();
      if (data[31:0] !== want.mapped_x || data[63:32] !== want.mapped_y ||
          flag !== want.clipped) begin
        bad_mappings++;
        if (bad_mappings <= 10)
          $display("mismatch: x exp %0d got %0d, y exp %0d got %0d, clipped exp %0b got %0b",
                   want.mapped_x, $signed(data[31:0]), want.mapped_y,
                   $signed(data[63:32]), want.clipped, flag);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // pixel_x, pixel_y
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // mapped_x, mapped_y
  logic        m_axis_tuser;   // clipped
  logic        cfg_wr_en_i;
  logic [2:0]  cfg_addr_i;
  logic [31:0] cfg_wdata_i;

  distortion_scoreboard maps = new();
  int                   cycle_count;

  lens_distortion_point_map_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // transfer monitor: inputs are noted before outputs are checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        maps.note_pixel(s_axis_tdata[11:0], s_axis_tdata[23:12]);
      if (m_axis_tvalid && m_axis_tready)
        maps.check_mapping(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_CAP) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // receiver backpressure in segments of random mode and length
  initial begin
    rx_mode_e mode;
    int       span;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      mode = rx_mode_e'($urandom_range(3));
      span = (mode == RX_HOLD) ? $urandom_range(1, 12) : $urandom_range(1, 40);
      for (int k = 0; k < span; k++) begin
        @(negedge clk_i);
        case (mode)
          RX_OPEN:   m_axis_tready = 1'b1;
          RX_RANDOM: m_axis_tready = 1'($urandom_range(1));
          RX_HOLD:   m_axis_tready = 1'b0;
          default:   m_axis_tready = k[0];
        endcase
      end
    end
  end

  // all driving tasks start and end at a falling edge
  task automatic send_pixel(logic [11:0] px, logic [11:0] py);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {py, px};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic idle(int n);
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 24'($urandom);
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    while (maps.pending_mappings.size() != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
  endtask

  task automatic apply_setup(logic [31:0] c, logic [31:0] fx, logic [31:0] fy,
                             logic [31:0] a1, logic [31:0] a2, logic [31:0] a3,
                             logic [31:0] t1, logic [31:0] t2);
    logic [31:0] vals [8];
    vals = '{c, fx, fy, a1, a2, a3, t1, t2};
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_wr_en_i = 1'b1;
      cfg_addr_i  = ldpm_pkg::reg_idx_e'(i);
      cfg_wdata_i = vals[i];
      @(posedge clk_i);
      maps.set_reg(ldpm_pkg::reg_idx_e'(i), vals[i]);
      @(negedge clk_i);
    end
    cfg_wr_en_i = 1'b0;
    cfg_wdata_i = $urandom;
  endtask

  function automatic logic [31:0] signed_span(int unsigned half);
    logic [31:0] v;
    v = $urandom_range(0, 2 * half);
    return v - half;
  endfunction

  function automatic logic [31:0] pick_reg_value(ldpm_pkg::reg_idx_e idx,
                                                 setup_style_e style);
    logic [31:0] edge_val;
    logic [31:0] v;
    case ($urandom_range(4))
      0:       edge_val = 32'h0000_0000;
      1:       edge_val = 32'h7FFF_FFFF;
      2:       edge_val = 32'h8000_0000;
      3:       edge_val = 32'hFFFF_FFFF;
      default: edge_val = 32'h0000_0001;
    endcase
    if (style == SETUP_EDGE || (style == SETUP_LENS && $urandom_range(7) == 0))
      v = edge_val;
    else if (style == SETUP_RAW)
      v = $urandom;
    else begin
      case (idx)
        ldpm_pkg::REG_CENTER_XY: v = {16'($urandom_range(16'h3000, 16'hD000)),
                                      16'($urandom_range(16'h3000, 16'hD000))};
        ldpm_pkg::REG_INV_FX,
        ldpm_pkg::REG_INV_FY:    v = $urandom_range(4194, 83886);  // focal 4000 .. 200 px
        ldpm_pkg::REG_K1:        v = signed_span(8388608);
        ldpm_pkg::REG_K2:        v = signed_span(2097152);
        ldpm_pkg::REG_K3:        v = signed_span(503316);
        default:                 v = signed_span(167772);
      endcase
    end
    if (idx == ldpm_pkg::REG_INV_FX || idx == ldpm_pkg::REG_INV_FY)
      v[31:24] = 8'h00;
    return v;
  endfunction

  function automatic logic [11:0] pick_pixel(logic [11:0] mid);
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? 12'hFFF : 12'h000;
      1:       return mid + 12'($urandom_range(0, 8)) - 12'd4;
      default: return 12'($urandom_range(4095));
    endcase
  endfunction

  initial begin
    setup_style_e style;
    int           left;
    int           burst;
    int           pause_at;
    bit           gappy;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_wr_en_i   = 1'b0;
    cfg_addr_i    = ldpm_pkg::REG_CENTER_XY;
    cfg_wdata_i   = '0;
    rst_ni        = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset values: zero reciprocal focal lengths give a zero mapping
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2048, 12'd1024);
    idle(2);

    // typical lens, barrel distortion
    apply_setup(32'h6000_8000, 32'd16777, 32'd16777, -32'sd4194304, 32'sd838861,
                -32'sd167772, 32'sd16777, -32'sd33554);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    idle(1);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2048, 12'd1536);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    send_pixel(12'd2049, 12'd1536);
    idle(1);

    // everything at its maximum: saturation throughout
    apply_setup(32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd2048, 12'd2048);
    idle(1);

    // most negative coefficients
    apply_setup(32'h0000_0000, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    idle(1);

    // one axis with zero reciprocal, smallest nonzero coefficients
    apply_setup(32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0001,
                32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd0);
    idle(1);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        3, 7:    style = SETUP_RAW;
        5:       style = SETUP_EDGE;
        default: style = SETUP_LENS;
      endcase
      apply_setup(pick_reg_value(ldpm_pkg::REG_CENTER_XY, style),
                  pick_reg_value(ldpm_pkg::REG_INV_FX, style),
                  pick_reg_value(ldpm_pkg::REG_INV_FY, style),
                  pick_reg_value(ldpm_pkg::REG_K1, style),
                  pick_reg_value(ldpm_pkg::REG_K2, style),
                  pick_reg_value(ldpm_pkg::REG_K3, style),
                  pick_reg_value(ldpm_pkg::REG_P1, style),
                  pick_reg_value(ldpm_pkg::REG_P2, style));
      gappy    = $urandom_range(3) != 0;
      pause_at = (ph == 0 || $urandom_range(2) == 0) ? $urandom_range(20, 110) : -1;
      left     = PHASE_ITEMS;
      while (left > 0) begin
        burst = $urandom_range(1, 32);
        if (burst > left)
          burst = left;
        repeat (burst) begin
          send_pixel(pick_pixel(maps.cen_x[15:4]), pick_pixel(maps.cen_y[15:4]));
          left--;
        end
        if (pause_at >= 0 && left <= pause_at) begin
          // hold the sender until the pipeline has delivered everything
          idle(1);
          drain();
          pause_at = -1;
        end else if (gappy) begin
          idle($urandom_range(1, 6));
        end
      end
      idle(1);
    end

    while (maps.pending_mappings.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    if (maps.bad_mappings == 0 && maps.pending_mappings.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
